@@ rtl/core/obn_pkg.sv @@
`default_nettype none

package obn_pkg;

	// Default output fraction width; one is 1 << OUT_FRAC_BITS.
	localparam int OUT_FRAC_BITS_DEF = 16;

	// Fixed widths set by the input format.
	localparam int IN_W      = 32;
	localparam int MAG_W     = 32;
	localparam int HALF_W    = 32;
	localparam int SQ_W      = 64;
	localparam int DEN_W     = 128;
	localparam int NUM_LANES = 8;
	localparam int NUM_DENS  = 3;

	// Lane assignment of the eight magnitudes worked out per vector.
	localparam int LANE_A1X = 0;
	localparam int LANE_A1Y = 1;
	localparam int LANE_A1Z = 2;
	localparam int LANE_A2X = 3;
	localparam int LANE_A2Y = 4;
	localparam int LANE_A3Z = 5;
	localparam int LANE_A3X = 6;
	localparam int LANE_A3Y = 7;

	// Which squared length a lane divides by.
	typedef enum logic [1:0] {
		DEN_FULL,
		DEN_PLANE,
		DEN_PROD
	} den_kind_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic neg_z;
		logic pos_y;
		logic pos_z;
		logic zero_all;
		logic zero_xy;
	} obn_side_t;

	function automatic den_kind_t lane_den(input int lane);
		den_kind_t k;
		case (lane)
			LANE_A2X, LANE_A2Y: k = DEN_PLANE;
			LANE_A3X, LANE_A3Y: k = DEN_PROD;
			default:            k = DEN_FULL;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/obn_if.sv @@
`default_nettype none

interface obn_vec_if import obn_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] normal_x;
	logic signed [IN_W-1:0] normal_y;
	logic signed [IN_W-1:0] normal_z;

	modport source(output valid, normal_x, normal_y, normal_z, input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface obn_frame_if import obn_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) ();
	localparam int AW = OUT_FRAC_BITS + 2;

	logic                 valid;
	logic                 ready;
	logic signed [AW-1:0] axis_one_x;
	logic signed [AW-1:0] axis_one_y;
	logic signed [AW-1:0] axis_one_z;
	logic signed [AW-1:0] axis_two_x;
	logic signed [AW-1:0] axis_two_y;
	logic                 axis_two_z;
	logic signed [AW-1:0] axis_three_x;
	logic signed [AW-1:0] axis_three_y;
	logic signed [AW-1:0] axis_three_z;
	logic                 degenerate;

	modport source(output valid, axis_one_x, axis_one_y, axis_one_z, axis_two_x,
		axis_two_y, axis_two_z, axis_three_x, axis_three_y, axis_three_z, degenerate,
		input ready);
	modport sink(input valid, axis_one_x, axis_one_y, axis_one_z, axis_two_x,
		axis_two_y, axis_two_z, axis_three_x, axis_three_y, axis_three_z, degenerate,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/obn_prep.sv @@
`default_nettype none

module obn_prep import obn_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	obn_vec_if.sink                   vec,
	output logic                      vld_out,
	input  wire logic                 rdy_dn,
	output obn_side_t                 side_out,
	output logic [DEN_W-1:0]          den_out [NUM_DENS],
	output logic signed [DEN_W+2*OUT_FRAC_BITS+5:0] r_out [NUM_LANES],
	output logic signed [DEN_W+2*OUT_FRAC_BITS+5:0] d_out [NUM_LANES]
);

	localparam int RW = DEN_W + 2*OUT_FRAC_BITS + 6;
	localparam int NS = 6;

	logic [NS:1]   vld_q;
	logic [NS+1:1] ld;

	// Stage 1: magnitudes and signs.
	logic [MAG_W-1:0] mx_s1, my_s1, mz_s1;
	obn_side_t        side_s1;
	// Stage 2: squares and cross products.
	logic [SQ_W-1:0]  sqx_s2, sqy_s2, sqz_s2, pxz_s2, pyz_s2;
	obn_side_t        side_s2;
	// Stage 3: squared lengths and partial products of the cross terms.
	logic [SQ_W-1:0]  sqx_s3, sqy_s3, sqz_s3, s_s3, s2_s3;
	logic [SQ_W-1:0]  xll_s3, xlh_s3, xhh_s3, yll_s3, ylh_s3, yhh_s3;
	obn_side_t        side_s3;
	// Stage 4: cross term squares and partial products of s * s2.
	logic [SQ_W-1:0]  sqx_s4, sqy_s4, sqz_s4, s_s4, s2_s4;
	logic [DEN_W-1:0] nxz_s4, nyz_s4;
	logic [SQ_W-1:0]  wll_s4, wlh_s4, whl_s4, whh_s4;
	obn_side_t        side_s4;
	// Stage 5: all numerators and denominators.
	logic [DEN_W-1:0] num_s5 [NUM_LANES];
	logic [DEN_W-1:0] den_s5 [NUM_DENS];
	obn_side_t        side_s5;
	// Stage 6: residual and running product seeds.
	logic signed [RW-1:0] r_s6 [NUM_LANES];
	logic signed [RW-1:0] d_s6 [NUM_LANES];
	logic [DEN_W-1:0]     den_s6 [NUM_DENS];
	obn_side_t            side_s6;

	logic [DEN_W-1:0]     num_c [NUM_LANES];
	logic signed [RW-1:0] r_c [NUM_LANES];
	logic signed [RW-1:0] d_c [NUM_LANES];

	function automatic logic [MAG_W-1:0] mag_of(input logic [IN_W-1:0] v);
		return v[IN_W-1] ? (~v + 1'b1) : v;
	endfunction

	// A stage loads when it is empty or when its content moves on.
	always_comb begin
		ld[NS+1] = rdy_dn;
		for (int i = NS; i >= 1; i--) begin
			ld[i] = ~vld_q[i] | ld[i+1];
		end
	end

	assign vec.ready = ld[1];
	assign vld_out   = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= vec.valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			mx_s1 <= mag_of(vec.normal_x);
			my_s1 <= mag_of(vec.normal_y);
			mz_s1 <= mag_of(vec.normal_z);
			side_s1.neg_x    <= vec.normal_x[IN_W-1];
			side_s1.neg_y    <= vec.normal_y[IN_W-1];
			side_s1.neg_z    <= vec.normal_z[IN_W-1];
			side_s1.pos_y    <= ~vec.normal_y[IN_W-1] & (|vec.normal_y);
			side_s1.pos_z    <= ~vec.normal_z[IN_W-1] & (|vec.normal_z);
			side_s1.zero_all <= 1'b0;
			side_s1.zero_xy  <= 1'b0;
		end
		if (ld[2]) begin
			sqx_s2  <= SQ_W'(mx_s1) * SQ_W'(mx_s1);
			sqy_s2  <= SQ_W'(my_s1) * SQ_W'(my_s1);
			sqz_s2  <= SQ_W'(mz_s1) * SQ_W'(mz_s1);
			pxz_s2  <= SQ_W'(mx_s1) * SQ_W'(mz_s1);
			pyz_s2  <= SQ_W'(my_s1) * SQ_W'(mz_s1);
			side_s2 <= side_s1;
		end
		if (ld[3]) begin
			sqx_s3  <= sqx_s2;
			sqy_s3  <= sqy_s2;
			sqz_s3  <= sqz_s2;
			s2_s3   <= sqx_s2 + sqy_s2;
			s_s3    <= sqx_s2 + sqy_s2 + sqz_s2;
			xll_s3  <= SQ_W'(pxz_s2[HALF_W-1:0]) * SQ_W'(pxz_s2[HALF_W-1:0]);
			xlh_s3  <= SQ_W'(pxz_s2[HALF_W-1:0]) * SQ_W'(pxz_s2[SQ_W-1:HALF_W]);
			xhh_s3  <= SQ_W'(pxz_s2[SQ_W-1:HALF_W]) * SQ_W'(pxz_s2[SQ_W-1:HALF_W]);
			yll_s3  <= SQ_W'(pyz_s2[HALF_W-1:0]) * SQ_W'(pyz_s2[HALF_W-1:0]);
			ylh_s3  <= SQ_W'(pyz_s2[HALF_W-1:0]) * SQ_W'(pyz_s2[SQ_W-1:HALF_W]);
			yhh_s3  <= SQ_W'(pyz_s2[SQ_W-1:HALF_W]) * SQ_W'(pyz_s2[SQ_W-1:HALF_W]);
			side_s3 <= side_s2;
		end
		if (ld[4]) begin
			sqx_s4 <= sqx_s3;
			sqy_s4 <= sqy_s3;
			sqz_s4 <= sqz_s3;
			s_s4   <= s_s3;
			s2_s4  <= s2_s3;
			nxz_s4 <= (DEN_W'(xhh_s3) << (2*HALF_W)) + (DEN_W'(xlh_s3) << (HALF_W+1))
				+ DEN_W'(xll_s3);
			nyz_s4 <= (DEN_W'(yhh_s3) << (2*HALF_W)) + (DEN_W'(ylh_s3) << (HALF_W+1))
				+ DEN_W'(yll_s3);
			wll_s4 <= SQ_W'(s_s3[HALF_W-1:0]) * SQ_W'(s2_s3[HALF_W-1:0]);
			wlh_s4 <= SQ_W'(s_s3[HALF_W-1:0]) * SQ_W'(s2_s3[SQ_W-1:HALF_W]);
			whl_s4 <= SQ_W'(s_s3[SQ_W-1:HALF_W]) * SQ_W'(s2_s3[HALF_W-1:0]);
			whh_s4 <= SQ_W'(s_s3[SQ_W-1:HALF_W]) * SQ_W'(s2_s3[SQ_W-1:HALF_W]);
			side_s4.neg_x    <= side_s3.neg_x;
			side_s4.neg_y    <= side_s3.neg_y;
			side_s4.neg_z    <= side_s3.neg_z;
			side_s4.pos_y    <= side_s3.pos_y;
			side_s4.pos_z    <= side_s3.pos_z;
			side_s4.zero_all <= (s_s3 == '0);
			side_s4.zero_xy  <= (s2_s3 == '0);
		end
		if (ld[5]) begin
			num_s5[LANE_A1X] <= DEN_W'(sqx_s4);
			num_s5[LANE_A1Y] <= DEN_W'(sqy_s4);
			num_s5[LANE_A1Z] <= DEN_W'(sqz_s4);
			num_s5[LANE_A2X] <= DEN_W'(sqy_s4);
			num_s5[LANE_A2Y] <= DEN_W'(sqx_s4);
			num_s5[LANE_A3Z] <= DEN_W'(s2_s4);
			num_s5[LANE_A3X] <= nxz_s4;
			num_s5[LANE_A3Y] <= nyz_s4;
			den_s5[DEN_FULL]  <= DEN_W'(s_s4);
			den_s5[DEN_PLANE] <= DEN_W'(s2_s4);
			den_s5[DEN_PROD]  <= (DEN_W'(whh_s4) << (2*HALF_W))
				+ ((DEN_W'(wlh_s4) + DEN_W'(whl_s4)) << HALF_W) + DEN_W'(wll_s4);
			side_s5 <= side_s4;
		end
		if (ld[6]) begin
			r_s6    <= r_c;
			d_s6    <= d_c;
			den_s6  <= den_s5;
			side_s6 <= side_s5;
		end
	end

	// Seed for q = 0: residual 4 N one^2 - den, running product den * (2q - 1) = -den.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			num_c[l] = num_s5[l];
			r_c[l]   = (RW'(num_c[l]) << (2*OUT_FRAC_BITS + 2)) - RW'(den_s5[lane_den(l)]);
			d_c[l]   = RW'(0) - RW'(den_s5[lane_den(l)]);
		end
	end

	assign side_out = side_s6;
	assign den_out  = den_s6;
	assign r_out    = r_s6;
	assign d_out    = d_s6;

endmodule

`default_nettype wire

@@ rtl/core/obn_cell.sv @@
`default_nettype none

module obn_cell import obn_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int BIT = OUT_FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 vld_in,
	output logic                      rdy_up,
	output logic                      vld_out,
	input  wire logic                 rdy_dn,
	input  wire obn_side_t            side_in,
	output obn_side_t                 side_out,
	input  wire logic [DEN_W-1:0]     den_in [NUM_DENS],
	output logic [DEN_W-1:0]          den_out [NUM_DENS],
	input  wire logic signed [DEN_W+2*OUT_FRAC_BITS+5:0] r_in [NUM_LANES],
	output logic signed [DEN_W+2*OUT_FRAC_BITS+5:0]      r_out [NUM_LANES],
	input  wire logic signed [DEN_W+2*OUT_FRAC_BITS+5:0] d_in [NUM_LANES],
	output logic signed [DEN_W+2*OUT_FRAC_BITS+5:0]      d_out [NUM_LANES],
	input  wire logic [OUT_FRAC_BITS:0] q_in [NUM_LANES],
	output logic [OUT_FRAC_BITS:0]      q_out [NUM_LANES]
);

	localparam int RW = DEN_W + 2*OUT_FRAC_BITS + 6;
	localparam int QW = OUT_FRAC_BITS + 1;

	logic                 vld_q;
	obn_side_t            side_q;
	logic [DEN_W-1:0]     den_q [NUM_DENS];
	logic signed [RW-1:0] r_q [NUM_LANES];
	logic signed [RW-1:0] d_q [NUM_LANES];
	logic [QW-1:0]        q_q [NUM_LANES];

	logic signed [RW-1:0] dx_c [NUM_LANES];
	logic signed [RW-1:0] e_c [NUM_LANES];
	logic signed [RW-1:0] rt_c [NUM_LANES];
	logic signed [RW-1:0] r_c [NUM_LANES];
	logic signed [RW-1:0] d_c [NUM_LANES];
	logic [QW-1:0]        q_c [NUM_LANES];
	logic [NUM_LANES-1:0] acc_c;
	logic [NUM_LANES-1:0] over_c, neg_c, seed_c;

	assign rdy_up = ~vld_q | rdy_dn;

	// Trial q + 2^BIT: subtract 2^(BIT+2) * (D + den * 2^BIT) from the residual.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			dx_c[l]  = RW'(den_in[lane_den(l)]);
			e_c[l]   = d_in[l] + (dx_c[l] << BIT);
			rt_c[l]  = r_in[l] - (e_c[l] << (BIT + 2));
			acc_c[l] = ~q_in[l][QW-1] & ~rt_c[l][RW-1];
			r_c[l]   = acc_c[l] ? rt_c[l] : r_in[l];
			d_c[l]   = acc_c[l] ? (d_in[l] + (dx_c[l] << (BIT + 1))) : d_in[l];
			q_c[l]   = q_in[l] | (acc_c[l] ? (QW'(1) << BIT) : QW'(0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy_up) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_up) begin
			side_q <= side_in;
			den_q  <= den_in;
			r_q    <= r_c;
			d_q    <= d_c;
			q_q    <= q_c;
		end
	end

	assign vld_out  = vld_q;
	assign side_out = side_q;
	assign den_out  = den_q;
	assign r_out    = r_q;
	assign d_out    = d_q;
	assign q_out    = q_q;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			over_c[l] = q_q[l][QW-1] & (|q_q[l][QW-2:0]);
			neg_c[l]  = (q_q[l] != '0) & r_q[l][RW-1];
			seed_c[l] = (q_q[l] == '0) & (d_q[l] != (RW'(0) - RW'(den_q[lane_den(l)])));
		end
	end

	// q never passes one.
	a_q_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (over_c == '0))
		else $error("obn_cell: magnitude above one");
	// Once a trial is taken the residual stays non-negative.
	a_res_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (neg_c == '0))
		else $error("obn_cell: negative residual after accepted trial");
	// With nothing taken yet the running product is still -den.
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (seed_c == '0))
		else $error("obn_cell: running product out of step");

endmodule

`default_nettype wire

@@ rtl/core/obn_post.sv @@
`default_nettype none

module obn_post import obn_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   vld_in,
	output logic                        rdy_up,
	input  wire obn_side_t              side_in,
	input  wire logic [OUT_FRAC_BITS:0] q_in [NUM_LANES],
	obn_frame_if.source                 frame
);

	localparam int AW = OUT_FRAC_BITS + 2;
	localparam int QW = OUT_FRAC_BITS + 1;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << OUT_FRAC_BITS;

	logic vld_q;
	logic signed [AW-1:0] a1x_q, a1y_q, a1z_q, a2x_q, a2y_q, a3x_q, a3y_q, a3z_q;
	logic deg_q;
	logic signed [AW-1:0] a1x_c, a1y_c, a1z_c, a2x_c, a2y_c, a3x_c, a3y_c, a3z_c;

	// Magnitude was rounded already; the sign goes on last.
	function automatic logic signed [AW-1:0] enc(input logic neg, input logic [QW-1:0] mag);
		logic [AW-1:0] m;
		m = AW'(mag);
		return neg ? (AW'(0) - m) : m;
	endfunction

	always_comb begin
		a1x_c = '0;
		a1y_c = '0;
		a1z_c = '0;
		a2x_c = '0;
		a2y_c = enc(1'b0, ONE_Q);
		a3x_c = '0;
		a3y_c = '0;
		a3z_c = '0;
		if (!side_in.zero_all) begin
			a1x_c = enc(side_in.neg_x, q_in[LANE_A1X]);
			a1y_c = enc(side_in.neg_y, q_in[LANE_A1Y]);
			a1z_c = enc(side_in.neg_z, q_in[LANE_A1Z]);
			if (side_in.zero_xy) begin
				a3x_c = enc(side_in.pos_z, ONE_Q);
			end else begin
				a2x_c = enc(side_in.pos_y, q_in[LANE_A2X]);
				a2y_c = enc(side_in.neg_x, q_in[LANE_A2Y]);
				a3x_c = enc(side_in.neg_x == side_in.neg_z, q_in[LANE_A3X]);
				a3y_c = enc(side_in.neg_y == side_in.neg_z, q_in[LANE_A3Y]);
				a3z_c = enc(1'b0, q_in[LANE_A3Z]);
			end
		end
	end

	assign rdy_up = ~vld_q | frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy_up) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_up) begin
			a1x_q <= a1x_c;
			a1y_q <= a1y_c;
			a1z_q <= a1z_c;
			a2x_q <= a2x_c;
			a2y_q <= a2y_c;
			a3x_q <= a3x_c;
			a3y_q <= a3y_c;
			a3z_q <= a3z_c;
			deg_q <= side_in.zero_all;
		end
	end

	assign frame.valid        = vld_q;
	assign frame.axis_one_x   = a1x_q;
	assign frame.axis_one_y   = a1y_q;
	assign frame.axis_one_z   = a1z_q;
	assign frame.axis_two_x   = a2x_q;
	assign frame.axis_two_y   = a2y_q;
	assign frame.axis_two_z   = 1'b0;
	assign frame.axis_three_x = a3x_q;
	assign frame.axis_three_y = a3y_q;
	assign frame.axis_three_z = a3z_q;
	assign frame.degenerate   = deg_q;

endmodule

`default_nettype wire

@@ rtl/core/orthonormal_basis_from_normal.sv @@
// Structure: six setup stages, one cell per result bit, one output register.
// Throughput: one vector per cycle while frame.ready holds; every stage holds its
// own valid bit and moves on when the stage after it is free, so bubbles close up
// under back-pressure.
// Reset: arst_n clears only the valid bits, emptying the pipeline at once.
`default_nettype none

module orthonormal_basis_from_normal import obn_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	obn_vec_if.sink     vec,
	obn_frame_if.source frame
);

	// Each magnitude is the largest q in [0, one] with (2q - 1)^2 * den <= 4 * num * one^2,
	// which is sqrt(num / den) * one rounded to nearest. Eight such magnitudes are found
	// side by side: the three components of the unit normal, the two of the in-plane
	// axis, and the three of the cross product. The setup stages form the numerators and
	// denominators exactly (up to 128 bits, with 32 x 32 partial products), then seed a
	// residual R = 4 N one^2 - den and a running product D = den * (2q - 1) for q = 0.
	//
	// The cell chain decides q one bit at a time, most significant first. Cell k tries
	// q + 2^k by subtracting 2^(k+2) * (D + den * 2^k) from R; a non-negative result
	// keeps the bit and updates D by den * 2^(k+1). Only shifts, three wide adds and a
	// sign compare per lane stand in each cell. Once q reaches one the later cells are shut
	// out, so the result saturates at one.
	//
	// The output stage applies the signs and the special cases: a zero vector gives
	// zero axes with (0, one, 0) as the second axis and raises degenerate; a normal
	// along z takes (0, one, 0) and (-sign(z) one, 0, 0) as the other two axes.

	localparam int RW = DEN_W + 2*OUT_FRAC_BITS + 6;
	localparam int QW = OUT_FRAC_BITS + 1;
	localparam int NC = OUT_FRAC_BITS + 1;
	localparam int AW = OUT_FRAC_BITS + 2;

	logic                 vld_c [NC+1];
	logic                 rdy_c [NC+1];
	obn_side_t            side_c [NC+1];
	logic [DEN_W-1:0]     den_c [NC+1][NUM_DENS];
	logic signed [RW-1:0] r_c [NC+1][NUM_LANES];
	logic signed [RW-1:0] d_c [NC+1][NUM_LANES];
	logic [QW-1:0]        q_c [NC+1][NUM_LANES];

	obn_prep #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vec     (vec),
		.vld_out (vld_c[0]),
		.rdy_dn  (rdy_c[0]),
		.side_out(side_c[0]),
		.den_out (den_c[0]),
		.r_out   (r_c[0]),
		.d_out   (d_c[0])
	);

	// The first cell starts every lane from q = 0.
	assign q_c[0] = '{default: '0};

	for (genvar c = 0; c < NC; c++) begin : g_cell
		obn_cell #(
			.OUT_FRAC_BITS(OUT_FRAC_BITS),
			.BIT          (OUT_FRAC_BITS - c)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_c[c]),
			.rdy_up  (rdy_c[c]),
			.vld_out (vld_c[c+1]),
			.rdy_dn  (rdy_c[c+1]),
			.side_in (side_c[c]),
			.side_out(side_c[c+1]),
			.den_in  (den_c[c]),
			.den_out (den_c[c+1]),
			.r_in    (r_c[c]),
			.r_out   (r_c[c+1]),
			.d_in    (d_c[c]),
			.d_out   (d_c[c+1]),
			.q_in    (q_c[c]),
			.q_out   (q_c[c+1])
		);
	end

	obn_post #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld_c[NC]),
		.rdy_up (rdy_c[NC]),
		.side_in(side_c[NC]),
		.q_in   (q_c[NC]),
		.frame  (frame)
	);

	localparam logic signed [AW-1:0] ONE_A = AW'(1) << OUT_FRAC_BITS;

	// A zero vector yields a zero first axis.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.degenerate) |->
			(frame.axis_one_x == '0 && frame.axis_one_y == '0 && frame.axis_one_z == '0))
		else $error("orthonormal_basis_from_normal: degenerate frame with nonzero axis one");
	// A zero vector keeps the fixed second axis.
	a_deg_two: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.degenerate) |->
			(frame.axis_two_y == ONE_A && frame.axis_two_x == '0))
		else $error("orthonormal_basis_from_normal: degenerate frame with wrong axis two");
	// Any nonzero vector has a component of at least one over root three.
	a_live_one: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && !frame.degenerate) |->
			(frame.axis_one_x != '0 || frame.axis_one_y != '0 || frame.axis_one_z != '0))
		else $error("orthonormal_basis_from_normal: empty axis one for nonzero vector");

endmodule

`default_nettype wire

@@ tb/sv/tb_orthonormal_basis_from_normal.sv @@
`default_nettype none

module tb_orthonormal_basis_from_normal;
	import obn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OFB      = OUT_FRAC_BITS_DEF;
	localparam int AW       = OFB + 2;
	localparam int ONE      = 1 << OFB;
	// Pipeline depth from the head of the block.
	localparam int LATENCY  = OFB + 8;
	localparam int N_RANDOM = 1700;
	localparam int CYCLE_LIMIT = 400000;

	// Wide enough for (|x| |z|)^2 scaled by four times one squared, and for
	// |n|^2 |(x, y)|^2 times an odd number squared.
	typedef logic [191:0] wide_t;

	typedef struct packed {
		logic signed [AW-1:0] a1x;
		logic signed [AW-1:0] a1y;
		logic signed [AW-1:0] a1z;
		logic signed [AW-1:0] a2x;
		logic signed [AW-1:0] a2y;
		logic                 a2z;
		logic signed [AW-1:0] a3x;
		logic signed [AW-1:0] a3y;
		logic signed [AW-1:0] a3z;
		logic                 degen;
	} frame_t;

	// The scoreboard works out the frame of every accepted vector and holds the
	// frames in arrival order until the block hands them back.
	class frame_scoreboard;
		frame_t pending_frames[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		// Rounded magnitude sqrt(num / den) in units of one, clamped at one.
		// The search keeps the largest q with (2q - 1)^2 den <= 4 num one^2,
		// which is round to nearest with ties away from zero.
		static function logic [AW-1:0] unit_ratio(wide_t num, wide_t den);
			wide_t lo, hi, mid, odd, lhs, rhs;
			lo  = 0;
			hi  = ONE;
			rhs = num << (2 * OFB + 2);
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				odd = 2 * mid - 1;
				lhs = den * odd * odd;
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			return lo[AW-1:0];
		endfunction

		// Sign is applied after rounding, so rounding is symmetric about zero.
		static function logic signed [AW-1:0] signed_unit(logic neg, logic [AW-1:0] mag);
			return neg ? -$signed(mag) : $signed(mag);
		endfunction

		function void note_vector(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
				logic signed [IN_W-1:0] z);
			logic [MAG_W-1:0] ax, ay, az;
			wide_t xx, yy, zz, plane, full;
			frame_t f;
			ax = x[IN_W-1] ? -x : x;
			ay = y[IN_W-1] ? -y : y;
			az = z[IN_W-1] ? -z : z;
			xx = wide_t'(ax) * wide_t'(ax);
			yy = wide_t'(ay) * wide_t'(ay);
			zz = wide_t'(az) * wide_t'(az);
			plane = xx + yy;
			full  = plane + zz;
			f = '0;
			f.a2y = ONE;
			if (full == 0) begin
				// The zero vector cannot be normalized.
				f.degen = 1'b1;
			end else begin
				f.a1x = signed_unit(x[IN_W-1], unit_ratio(xx, full));
				f.a1y = signed_unit(y[IN_W-1], unit_ratio(yy, full));
				f.a1z = signed_unit(z[IN_W-1], unit_ratio(zz, full));
				if (plane == 0) begin
					// Normal along z: second axis stays (0, 1, 0).
					f.a3x = signed_unit(!z[IN_W-1] && (z != 0), ONE);
				end else begin
					f.a2x = signed_unit(!y[IN_W-1] && (y != 0), unit_ratio(yy, plane));
					f.a2y = signed_unit(x[IN_W-1], unit_ratio(xx, plane));
					f.a3x = signed_unit(x[IN_W-1] == z[IN_W-1],
						unit_ratio(xx * zz, full * plane));
					f.a3y = signed_unit(y[IN_W-1] == z[IN_W-1],
						unit_ratio(yy * zz, full * plane));
					f.a3z = signed_unit(1'b0, unit_ratio(plane, full));
				end
			end
			pending_frames.push_back(f);
		endfunction

		function void report(string what, longint got, longint want);
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			errors++;
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (pending_frames.size() == 0) begin
				$display("[%0t] frame beat with no vector outstanding", $realtime);
				errors++;
				return;
			end
			want = pending_frames.pop_front();
			if (got.a1x !== want.a1x) report("axis_one_x", got.a1x, want.a1x);
			if (got.a1y !== want.a1y) report("axis_one_y", got.a1y, want.a1y);
			if (got.a1z !== want.a1z) report("axis_one_z", got.a1z, want.a1z);
			if (got.a2x !== want.a2x) report("axis_two_x", got.a2x, want.a2x);
			if (got.a2y !== want.a2y) report("axis_two_y", got.a2y, want.a2y);
			if (got.a2z !== want.a2z) report("axis_two_z", got.a2z, want.a2z);
			if (got.a3x !== want.a3x) report("axis_three_x", got.a3x, want.a3x);
			if (got.a3y !== want.a3y) report("axis_three_y", got.a3y, want.a3y);
			if (got.a3z !== want.a3z) report("axis_three_z", got.a3z, want.a3z);
			if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	obn_vec_if   vec();
	obn_frame_if #(.OUT_FRAC_BITS(OFB)) frame();

	orthonormal_basis_from_normal #(.OUT_FRAC_BITS(OFB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec),
		.frame  (frame)
	);

	frame_scoreboard sb = new();

	// Percent of cycles in which each side holds off; changed per phase.
	int vec_idle_pct   = 17;
	int frame_idle_pct = 80;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Frame side: sample the beat that completed at this edge, then pick the
	// ready value for the next cycle.
	always @(posedge clk) begin
		if (arst_n && frame.valid && frame.ready) begin
			sb.check_frame('{frame.axis_one_x, frame.axis_one_y, frame.axis_one_z,
				frame.axis_two_x, frame.axis_two_y, frame.axis_two_z,
				frame.axis_three_x, frame.axis_three_y, frame.axis_three_z,
				frame.degenerate});
		end
		if (!arst_n) begin
			frame.ready <= 1'b0;
		end else begin
			frame.ready <= ($urandom_range(99) >= frame_idle_pct);
		end
	end

	// Present one vector and hold it until the block takes it. Valid is only
	// lowered for an idle gap, so back-to-back beats keep it high.
	task automatic send_vector(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
			logic signed [IN_W-1:0] z);
		while ($urandom_range(99) < vec_idle_pct) begin
			vec.valid <= 1'b0;
			@(posedge clk);
		end
		vec.valid    <= 1'b1;
		vec.normal_x <= x;
		vec.normal_y <= y;
		vec.normal_z <= z;
		do @(posedge clk); while (!vec.ready);
		sb.note_vector(x, y, z);
	endtask

	// Random component: mostly full range, sometimes small, zero or an extreme,
	// so that plane and axis cases come up often.
	function automatic logic signed [IN_W-1:0] rand_component();
		logic signed [IN_W-1:0] v;
		case ($urandom_range(9))
			0:       v = 0;
			1:       v = $signed($urandom_range(7)) - 3;
			2:       v = $signed($urandom_range(131071)) - 65536;
			3:       v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			send_vector(rand_component(), rand_component(), rand_component());
		end
	endtask

	localparam logic signed [IN_W-1:0] MAXV = 32'sh7fffffff;
	localparam logic signed [IN_W-1:0] MINV = 32'sh80000000;

	initial begin
		arst_n       <= 1'b0;
		vec.valid    <= 1'b0;
		vec.normal_x <= '0;
		vec.normal_y <= '0;
		vec.normal_z <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the zero vector, normals along each axis with both signs,
		// the extremes of the input range, and tiny vectors where rounding
		// lands close to a half.
		send_vector(0, 0, 0);
		send_vector(0, 0, 32'sh10000);
		send_vector(0, 0, -32'sh10000);
		send_vector(0, 0, MINV);
		send_vector(0, 0, MAXV);
		send_vector(32'sh10000, 0, 0);
		send_vector(-32'sh10000, 0, 0);
		send_vector(0, 32'sh10000, 0);
		send_vector(0, -32'sh10000, 0);
		send_vector(MAXV, MAXV, MAXV);
		send_vector(MINV, MINV, MINV);
		send_vector(MINV, MAXV, MINV);
		send_vector(MAXV, MINV, MAXV);
		send_vector(MINV, 0, 0);
		send_vector(0, MINV, 1);
		send_vector(1, 1, 1);
		send_vector(-1, 1, -1);
		send_vector(1, 0, 1);
		send_vector(1, 2, 2);
		send_vector(-3, 4, 0);
		send_vector(1, -1, 0);
		send_vector(32'h12345678, 32'hedcba987, 32'h0f0f0f0f);
		send_vector(-1, -1, MAXV);

		// Random: three phases of idling on the two sides.
		run_random(N_RANDOM / 3);
		vec_idle_pct   = 80;
		frame_idle_pct = 17;
		run_random(N_RANDOM / 3);
		vec_idle_pct   = 0;
		frame_idle_pct = 0;
		run_random(N_RANDOM - 2 * (N_RANDOM / 3));
		vec.valid <= 1'b0;

		// Drain, then let the pipeline settle to catch any stray beat.
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
